/* rtl/ptt_pkg.sv */
// Shared types and constants for the periodic task timer table.
// Used by ptt_cell, ptt_head and periodic_task_timer_table.
package ptt_pkg;

  localparam int SLOTS = 32;
  localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] KIND_SCHEDULE   = 2'd0;
  localparam logic [1:0] KIND_UNSCHEDULE = 2'd1;
  localparam logic [1:0] KIND_TICK       = 2'd2;

  localparam logic [31:0] ONE_SHOT = 32'hFFFF_FFFF;
  localparam logic [31:0] LATE_THRESHOLD_RST = 32'd10;

  typedef enum logic [2:0] {
    EV_SCHEDULED   = 3'd0,
    EV_FULL        = 3'd1,
    EV_UNSCHEDULED = 3'd2,
    EV_IGNORED     = 3'd3,
    EV_FIRED       = 3'd4,
    EV_IDLE        = 3'd5
  } ev_t;

  typedef struct packed {
    logic        occ;
    logic [31:0] due;
    logic [31:0] per;
  } slot_rec_t;

  typedef struct packed {
    logic        hit;
    logic        late;
    logic [30:0] delay;
  } head_res_t;

endpackage

/* rtl/ptt_cell.sv */
// One timer slot of the ring: occupancy, due time and reload period.
// Depends on ptt_pkg for the slot record type.
module ptt_cell
  import ptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  logic      load,
  input  logic      clear,
  input  slot_rec_t link_in,
  input  slot_rec_t load_rec,
  output slot_rec_t rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.occ <= 1'b0;
    end else if (shift) begin
      rec <= link_in;
    end else if (load) begin
      rec <= load_rec;
    end else if (clear) begin
      rec.occ <= 1'b0;
    end
  end

endmodule

/* rtl/ptt_head.sv */
// Evaluates the slot at the head of the ring during a tick scan.
// Depends on ptt_pkg; produces the fired result and the reloaded record.
module ptt_head
  import ptt_pkg::*;
(
  input  slot_rec_t   rec,
  input  logic [31:0] now,
  input  logic [31:0] late_threshold,
  output head_res_t   res,
  output slot_rec_t   reload
);

  logic [31:0] elapsed;
  logic        one_shot;

  always_comb begin
    elapsed   = now - rec.due;
    one_shot  = (rec.per == ONE_SHOT);
    // wrap-safe: due when the difference is not negative
    res.hit   = rec.occ && !elapsed[31];
    res.late  = elapsed > late_threshold;
    res.delay = elapsed[30:0];
    reload    = rec;
    if (res.hit) begin
      if (one_shot) begin
        reload.occ = 1'b0;
      end else begin
        reload.due = now + rec.per;
      end
    end
  end

endmodule

/* rtl/periodic_task_timer_table.sv */
// Top level of the periodic task timer table: ring of slot cells, head unit,
// scan sequencer and output register. Depends on ptt_pkg, ptt_cell, ptt_head.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | kind, now, first_due, period, slot
//  out     | out_valid / out_ready | event_res, slot_id, delay, late, last
//  cfg     | cfg_valid / cfg_ready | cfg_data (late_threshold)
//
// Schedule, unschedule and unknown items each give one item.
// A tick rotates the ring of SLOTS cells once past the head unit, one slot per
// cycle unless the rotation is held, then gives the final item. A stalled output
// holds the rotation when a second fired slot reaches the head while an earlier
// fired item is still held.
// Synchronous reset empties every slot and sets late_threshold to 10.
module periodic_task_timer_table
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] now,
  input  logic [31:0] first_due,
  input  logic [31:0] period,
  input  logic [5:0]  slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [4:0]  slot_id,
  output logic [30:0] delay,
  output logic        late,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t      state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [31:0] late_threshold;
  logic [31:0] tick_now;
  logic        pend_v;
  logic [4:0]  pend_id;
  logic [30:0] pend_delay;
  logic        pend_late;

  slot_rec_t   recs [SLOTS];
  slot_rec_t   reload;
  slot_rec_t   load_rec;
  head_res_t   head;
  logic [SLOTS-1:0] occ_vec, free_vec, first_free, load_vec, clear_vec;
  logic [4:0]  free_idx;
  logic        full, in_range;
  logic        can_push, accept, step, push_scan, push_flush, single_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      late_threshold <= LATE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      late_threshold <= cfg_data;
    end
  end

  // ring of cells; the head unit feeds the tail
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ptt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (step),
      .load     (load_vec[i]),
      .clear    (clear_vec[i]),
      .link_in  ((i == SLOTS - 1) ? reload : recs[(i + 1) % SLOTS]),
      .load_rec (load_rec),
      .rec      (recs[i])
    );
    assign occ_vec[i]   = recs[i].occ;
    assign clear_vec[i] = accept && (kind == KIND_UNSCHEDULE) && (slot == 6'(i));
  end

  ptt_head u_head (
    .rec            (recs[0]),
    .now            (tick_now),
    .late_threshold (late_threshold),
    .res            (head),
    .reload         (reload)
  );

  // lowest free slot: isolate the lowest set bit of the free mask
  always_comb begin
    free_vec   = ~occ_vec;
    first_free = free_vec & (~free_vec + SLOTS'(1));
    full       = &occ_vec;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first_free[i]) begin
        free_idx = free_idx | 5'(i);
      end
    end
    in_range     = {1'b0, slot} < 7'(SLOTS);
    load_rec.occ = 1'b1;
    load_rec.due = first_due;
    load_rec.per = period;
  end

  assign can_push    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE) && can_push;
  assign accept      = in_valid && in_ready;
  assign single_load = accept && (kind != KIND_TICK);
  assign step        = (state == S_SCAN) && (!(head.hit && pend_v) || can_push);
  assign push_scan   = step && head.hit && pend_v;
  assign push_flush  = (state == S_FLUSH) && can_push;
  assign load_vec    = (accept && (kind == KIND_SCHEDULE) && !full) ? first_free : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (kind == KIND_TICK)) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (step && (cnt == CNT_W'(SLOTS - 1))) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (push_flush) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      pend_v <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt    <= '0;
        pend_v <= 1'b0;
      end else if (step) begin
        cnt <= cnt + CNT_W'(1);
        if (head.hit) pend_v <= 1'b1;
      end else if (push_flush) begin
        pend_v <= 1'b0;
        cnt    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_now <= now;
    end
    if (step && head.hit) begin
      pend_id    <= 5'(cnt);
      pend_delay <= head.delay;
      pend_late  <= head.late;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (single_load || push_scan || push_flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (single_load) begin
      delay <= '0;
      late  <= 1'b0;
      last  <= 1'b1;
      case (kind)
        KIND_SCHEDULE: begin
          event_res <= full ? EV_FULL : EV_SCHEDULED;
          slot_id   <= full ? 5'd0 : free_idx;
        end
        KIND_UNSCHEDULE: begin
          event_res <= in_range ? EV_UNSCHEDULED : EV_IGNORED;
          slot_id   <= in_range ? slot[4:0] : 5'd0;
        end
        default: begin
          event_res <= EV_IGNORED;
          slot_id   <= 5'd0;
        end
      endcase
    end else if (push_scan || push_flush) begin
      // emit the held fired item, or an idle item if no slot fired; the final one of a tick carries last
      last <= push_flush;
      if (push_flush && !pend_v) begin
        event_res <= EV_IDLE;
        slot_id   <= 5'd0;
        delay     <= '0;
        late      <= 1'b0;
      end else begin
        event_res <= EV_FIRED;
        slot_id   <= pend_id;
        delay     <= pend_delay;
        late      <= pend_late;
      end
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_v)
    else $error("pending fired item left over outside a scan");

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == '0))
    else $error("scan counter not cleared, ring not back home");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (step && (cnt == CNT_W'(SLOTS - 1))) |=> (state == S_FLUSH))
    else $error("scan did not end after a full rotation");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res != EV_FIRED)) |-> last)
    else $error("non-fired item without last");

  a_fired_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == EV_FIRED)) |-> ({1'b0, slot_id} < 6'(SLOTS)))
    else $error("fired slot out of range");

endmodule

/* test/periodic_task_timer_table_tb.sv */
// Self-checking testbench for periodic_task_timer_table: directed cases, a full-table
// backpressure run and random schedule/unschedule/tick traffic, checked item by item.
// Depends on ptt_pkg and the periodic_task_timer_table RTL.
module periodic_task_timer_table_tb;
  import ptt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = SLOTS + 8;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] first_due;
    logic [31:0] period;
    logic [5:0]  slot;
  } table_item_t;

  typedef struct {
    ev_t         ev;
    logic [4:0]  id;
    logic [30:0] dly;
    logic        is_late;
    logic        is_last;
  } event_rec_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [31:0] now;
  logic [31:0] first_due;
  logic [31:0] period;
  logic [5:0]  slot;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  event_res;
  logic [4:0]  slot_id;
  logic [30:0] delay;
  logic        late;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // Mirror of the slot table
  logic [SLOTS-1:0] slot_busy;
  logic [31:0]      slot_due [SLOTS];
  logic [31:0]      slot_reload [SLOTS];
  logic [31:0]      late_limit;

  event_rec_t  expected_events[$];
  bit          steady_run;
  int unsigned stall_request;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned fired_count;
  int unsigned late_count;
  int unsigned full_count;
  int unsigned idle_count;

  periodic_task_timer_table uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still outstanding", expected_events.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function automatic event_rec_t make_result(input ev_t ev, input int unsigned id,
                                             input logic [30:0] dly, input logic lt);
    event_rec_t r;
    r.ev = ev;
    r.id = id[4:0];
    r.dly = dly;
    r.is_late = lt;
    r.is_last = 1'b0;
    return r;
  endfunction

  function automatic void timer_table_step(input table_item_t it);
    event_rec_t  burst[$];
    logic [31:0] elapsed;
    int unsigned idx;
    case (it.kind)
      KIND_SCHEDULE: begin
        if (&slot_busy) begin
          burst.push_back(make_result(EV_FULL, 0, '0, 1'b0));
          full_count++;
        end else begin
          idx = 0;
          while (idx < SLOTS - 1 && slot_busy[idx]) idx++;
          slot_busy[idx] = 1'b1;
          slot_due[idx] = it.first_due;
          slot_reload[idx] = it.period;
          burst.push_back(make_result(EV_SCHEDULED, idx, '0, 1'b0));
        end
      end
      KIND_UNSCHEDULE: begin
        if (it.slot >= SLOTS) begin
          burst.push_back(make_result(EV_IGNORED, 0, '0, 1'b0));
        end else begin
          slot_busy[it.slot[4:0]] = 1'b0;
          burst.push_back(make_result(EV_UNSCHEDULED, it.slot, '0, 1'b0));
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          elapsed = it.now - slot_due[i];
          if (slot_busy[i] && !elapsed[31]) begin
            burst.push_back(make_result(EV_FIRED, i, elapsed[30:0], elapsed > late_limit));
            fired_count++;
            if (elapsed > late_limit) late_count++;
            // reload periodic slots, drop one-shots
            if (slot_reload[i] != ONE_SHOT) slot_due[i] = it.now + slot_reload[i];
            else slot_busy[i] = 1'b0;
          end
        end
        if (burst.size() == 0) begin
          burst.push_back(make_result(EV_IDLE, 0, '0, 1'b0));
          idle_count++;
        end
      end
      default: begin
        burst.push_back(make_result(EV_IGNORED, 0, '0, 1'b0));
      end
    endcase
    burst[burst.size() - 1].is_last = 1'b1;
    foreach (burst[i]) expected_events.push_back(burst[i]);
  endfunction

  function automatic table_item_t make_item(input logic [1:0] k, input logic [31:0] t,
                                            input logic [31:0] due, input logic [31:0] per,
                                            input logic [5:0] s);
    table_item_t it;
    it.kind = k;
    it.now = t;
    it.first_due = due;
    it.period = per;
    it.slot = s;
    return it;
  endfunction

  // Leaves in_valid high on return; the caller either sends again or ends the phase.
  task automatic send_item(input table_item_t it);
    while (!steady_run && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    now <= it.now;
    first_due <= it.first_due;
    period <= it.period;
    slot <= it.slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timer_table_step(it);
    items_sent++;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_late_threshold(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    late_limit = value;
  endtask

  task automatic test_directed_cases();
    send_item(make_item(KIND_TICK, 32'd0, $urandom, $urandom, 6'($urandom_range(63))));
    send_item(make_item(KIND_UNUSED, $urandom, $urandom, $urandom,
                        6'($urandom_range(63))));
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd63));
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd32));
    // free slots answer unscheduled anyway
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd0));
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd31));
    // due times and reloads that wrap around zero
    send_item(make_item(KIND_SCHEDULE, $urandom, 32'hFFFF_FFF0, 32'd32, 6'd0));
    send_item(make_item(KIND_SCHEDULE, $urandom, 32'd5, ONE_SHOT, 6'd0));
    send_item(make_item(KIND_SCHEDULE, $urandom, 32'd0, 32'd0, 6'd0));
    send_item(make_item(KIND_SCHEDULE, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'd0));
    send_item(make_item(KIND_TICK, 32'd4, $urandom, $urandom, 6'd0));
    send_item(make_item(KIND_TICK, 32'd5, $urandom, $urandom, 6'd0));
    send_item(make_item(KIND_TICK, 32'd5, $urandom, $urandom, 6'd0));
    // one-shot slot was freed and is reused
    send_item(make_item(KIND_SCHEDULE, $urandom, 32'd1, ONE_SHOT, 6'd0));
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd0));
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd2));
    send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, 6'd3));
    // delay at its maximum, then just past the due window
    send_item(make_item(KIND_SCHEDULE, $urandom, 32'd0, ONE_SHOT, 6'd0));
    send_item(make_item(KIND_TICK, 32'h8000_0000, $urandom, $urandom, 6'd0));
    send_item(make_item(KIND_TICK, 32'h7FFF_FFFF, $urandom, $urandom, 6'd0));
    send_item(make_item(KIND_TICK, 32'hFFFF_FFFF, $urandom, $urandom, 6'd0));
  endtask

  task automatic test_full_table_backpressure();
    for (int i = 0; i < SLOTS; i++)
      send_item(make_item(KIND_SCHEDULE, $urandom, 32'd1000 + i, 32'd7 + i % 3,
                          6'($urandom_range(63))));
    send_item(make_item(KIND_SCHEDULE, $urandom, $urandom, $urandom,
                        6'($urandom_range(63))));
    // hold the sink so every slot firing backs up into the input
    stall_request = 300;
    for (int i = 0; i < 4; i++)
      send_item(make_item(KIND_TICK, 32'd1040 + 20 * i, $urandom, $urandom, 6'd0));
    for (int i = 0; i < SLOTS; i++)
      send_item(make_item(KIND_UNSCHEDULE, $urandom, $urandom, $urandom, i[5:0]));
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input logic [31:0] start);
    table_item_t it;
    logic [31:0] wall;
    int unsigned roll;
    wall = start;
    repeat (n_items) begin
      roll = $urandom_range(99);
      it = make_item(KIND_UNUSED, $urandom, $urandom, $urandom, 6'($urandom_range(63)));
      if (roll < 30) begin
        it.kind = KIND_SCHEDULE;
        if ($urandom_range(9) != 0) it.first_due = wall + $urandom_range(40);
        case ($urandom_range(9))
          0: it.period = ONE_SHOT;
          1: it.period = 32'd0;
          2: ;
          default: it.period = $urandom_range(1, 60);
        endcase
      end else if (roll < 65) begin
        it.kind = KIND_TICK;
        wall = wall + $urandom_range(25);
        // mostly advance steadily, now and then jump anywhere
        if ($urandom_range(19) != 0) it.now = wall;
      end else if (roll < 88) begin
        it.kind = KIND_UNSCHEDULE;
        it.slot = ($urandom_range(7) == 0) ? 6'($urandom_range(32, 63))
                                           : 6'($urandom_range(31));
      end
      send_item(it);
    end
  endtask

  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_run || ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin : result_check
    event_rec_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_events.size() == 0) begin
        report_mismatch("result with nothing outstanding", event_res, slot_id);
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
        if (slot_id !== want.id) report_mismatch("slot_id", slot_id, want.id);
        if (delay !== want.dly) report_mismatch("delay", delay, want.dly);
        if (late !== want.is_late) report_mismatch("late", late, want.is_late);
        if (last !== want.is_last) report_mismatch("last", last, want.is_last);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_SCHEDULE;
    now = '0;
    first_due = '0;
    period = '0;
    slot = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    slot_busy = '0;
    foreach (slot_due[i]) begin
      slot_due[i] = '0;
      slot_reload[i] = '0;
    end
    late_limit = LATE_THRESHOLD_RST;
    steady_run = 1'b0;
    stall_request = 0;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    fired_count = 0;
    late_count = 0;
    full_count = 0;
    idle_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    finish_phase();
    set_late_threshold(32'd25);
    test_full_table_backpressure();
    finish_phase();
    set_late_threshold(32'd0);
    test_random_traffic(80, 32'h0000_0100);
    finish_phase();
    set_late_threshold(32'hFFFF_FFFF);
    steady_run = 1'b1;
    test_random_traffic(40, 32'hFFFF_FF00);
    steady_run = 1'b0;
    test_random_traffic(40, 32'h0000_0040);
    finish_phase();
    set_late_threshold($urandom_range(3, 30));
    test_random_traffic(80, $urandom);
    finish_phase();

    $display("covered %0d items and %0d results over thresholds 10, 25, 0, max and random",
             items_sent, results_seen);
    $display("fired %0d (late %0d), table full %0d, idle ticks %0d",
             fired_count, late_count, full_count, idle_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
